// ----- src/lrbc_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the lamp and radio button controller
package lrbc_pkg;

  // field and register widths
  localparam int unsigned DebounceW   = 8;
  localparam int unsigned PressW      = 13;
  localparam int unsigned LinkW       = 11;
  localparam int unsigned BlinkW      = 7;
  localparam int unsigned PairW       = 11;
  localparam int unsigned IdleW       = 13;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned CfgIndexW   = 3;

  // default time base: ticks per tenth of a second
  localparam int unsigned TicksPerTenthDef = 100;

  // extra hold time above the long-press threshold at which the press timer stops
  localparam logic [PressW:0] PressCapExtra = 14'd100;

  // lamp state codes
  localparam logic [ModeW-1:0] LampHalf = 2'd0;
  localparam logic [ModeW-1:0] LampFull = 2'd1;
  localparam logic [ModeW-1:0] LampOff  = 2'd2;

  // radio state codes
  localparam logic [ModeW-1:0] RadioPair = 2'd0;
  localparam logic [ModeW-1:0] RadioConn = 2'd1;
  localparam logic [ModeW-1:0] RadioOff  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegDebounce      = 3'd0;
  localparam logic [CfgIndexW-1:0] RegLongPress     = 3'd1;
  localparam logic [CfgIndexW-1:0] RegStatusConfirm = 3'd2;
  localparam logic [CfgIndexW-1:0] RegBlinkPeriod   = 3'd3;
  localparam logic [CfgIndexW-1:0] RegPairTimeout   = 3'd4;
  localparam logic [CfgIndexW-1:0] RegSleep         = 3'd5;

  // configuration reset values
  localparam logic [DebounceW-1:0] DebounceRst      = 8'd35;
  localparam logic [PressW-1:0]    LongPressRst     = 13'd3000;
  localparam logic [LinkW-1:0]     StatusConfirmRst = 11'd1000;
  localparam logic [BlinkW-1:0]    BlinkPeriodRst   = 7'd125;
  localparam logic [PairW-1:0]     PairTimeoutRst   = 11'd1200;
  localparam logic [IdleW-1:0]     SleepRst         = 13'd4890;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic [PressW-1:0]    long_press_ms;
    logic [LinkW-1:0]     status_confirm_ms;
    logic [BlinkW-1:0]    blink_period_ms;
    logic [PairW-1:0]     pairing_timeout;
    logic [IdleW-1:0]     sleep_ms;
  } cfg_t;

  // controller state carried from one poll to the next
  typedef struct packed {
    logic                 debounced_key;
    logic [DebounceW-1:0] debounce_count;
    logic                 key_held;
    logic                 key_edge;
    logic                 press_armed;
    logic [PressW-1:0]    press_count;
    logic [ModeW-1:0]     lamp_state;
    logic [ModeW-1:0]     radio_state;
    logic [LinkW-1:0]     link_count;
    logic [BlinkW-1:0]    blink_count;
    logic                 blink_due;
    logic                 led_level;
    logic [PairW-1:0]     pairing_count;
    logic [IdleW-1:0]     idle_count;
  } state_t;

  typedef struct packed {
    logic [ModeW-1:0] lamp_mode;
    logic             lamp_low_enable;
    logic             lamp_high_enable;
    logic [ModeW-1:0] radio_mode;
    logic             radio_enable;
    logic             radio_led;
    logic             sleep_request;
  } result_t;

endpackage

// ----- src/lrbc_cfg.sv -----
`timescale 1ns / 1ps
// configuration register file of the lamp and radio button controller
module lrbc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lrbc_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [lrbc_pkg::CfgDataW-1:0]      cfg_data_i,
  output lrbc_pkg::cfg_t                     cfg_o
);
  import lrbc_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= DebounceRst;
      cfg_q.long_press_ms     <= LongPressRst;
      cfg_q.status_confirm_ms <= StatusConfirmRst;
      cfg_q.blink_period_ms   <= BlinkPeriodRst;
      cfg_q.pairing_timeout   <= PairTimeoutRst;
      cfg_q.sleep_ms          <= SleepRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegDebounce:      cfg_q.debounce_ms       <= cfg_data_i[DebounceW-1:0];
        RegLongPress:     cfg_q.long_press_ms     <= cfg_data_i[PressW-1:0];
        RegStatusConfirm: cfg_q.status_confirm_ms <= cfg_data_i[LinkW-1:0];
        RegBlinkPeriod:   cfg_q.blink_period_ms   <= cfg_data_i[BlinkW-1:0];
        RegPairTimeout:   cfg_q.pairing_timeout   <= cfg_data_i[PairW-1:0];
        RegSleep:         cfg_q.sleep_ms          <= cfg_data_i[IdleW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/lrbc_step.sv -----
`timescale 1ns / 1ps
// single-poll update: timers, debounce, press handling, radio and lamp state
module lrbc_step #(
  parameter int unsigned TICKS_PER_TENTH = lrbc_pkg::TicksPerTenthDef,
  parameter int unsigned TenthW = (TICKS_PER_TENTH > 1) ? $clog2(TICKS_PER_TENTH) : 1
) (
  input  lrbc_pkg::cfg_t    cfg_i,
  input  lrbc_pkg::state_t  state_i,
  input  logic [TenthW-1:0] tenth_count_i,
  input  logic              tick_elapsed_i,
  input  logic              key_level_i,
  input  logic              link_status_i,
  output lrbc_pkg::state_t  state_o,
  output logic [TenthW-1:0] tenth_count_o,
  output lrbc_pkg::result_t result_o
);
  import lrbc_pkg::*;

  localparam logic [TenthW:0] TenthLimit = (TenthW + 1)'(TICKS_PER_TENTH);

  state_t            st;
  logic [TenthW:0]   tenth_inc;
  logic [TenthW-1:0] tenth_cnt;
  logic              tenth_due;
  logic [PressW:0]   cap_sum;
  logic [PressW-1:0] press_cap;
  logic [BlinkW:0]   blink_inc;
  logic [IdleW:0]    idle_inc;
  logic [LinkW:0]    link_sum;
  logic              sleep_due;
  logic              pressed;

  always_comb begin
    st        = state_i;
    tenth_cnt = tenth_count_i;
    tenth_due = 1'b0;
    sleep_due = 1'b0;
    tenth_inc = {1'b0, tenth_count_i} + 1'b1;
    cap_sum   = {1'b0, cfg_i.long_press_ms} + PressCapExtra;
    press_cap = cap_sum[PressW] ? {PressW{1'b1}} : cap_sum[PressW-1:0];
    blink_inc = {1'b0, state_i.blink_count} + 1'b1;
    idle_inc  = {1'b0, state_i.idle_count} + 1'b1;
    link_sum  = {1'b0, state_i.link_count} + (LinkW + 1)'(3);
    pressed   = 1'b0;

    // timers advanced by the 1 ms tick
    if (tick_elapsed_i) begin
      if (tenth_inc >= TenthLimit) begin
        tenth_cnt = '0;
        tenth_due = 1'b1;
      end else begin
        tenth_cnt = tenth_inc[TenthW-1:0];
      end
      st.debounce_count = state_i.debounce_count + 1'b1;
      if (state_i.press_count < press_cap) st.press_count = state_i.press_count + 1'b1;
      if (blink_inc >= {1'b0, cfg_i.blink_period_ms}) begin
        st.blink_count = '0;
        st.blink_due   = 1'b1;
      end else begin
        st.blink_count = blink_inc[BlinkW-1:0];
      end
      if (idle_inc > {1'b0, cfg_i.sleep_ms}) begin
        st.idle_count = '0;
        sleep_due     = 1'b1;
      end else begin
        st.idle_count = idle_inc[IdleW-1:0];
      end
      // link-status counter
      case (state_i.radio_state)
        RadioPair: begin
          if (link_status_i) st.link_count = '0;
          else if (state_i.link_count != {LinkW{1'b1}})
            st.link_count = state_i.link_count + 1'b1;
        end
        RadioConn: begin
          if (link_status_i)
            st.link_count = link_sum[LinkW] ? {LinkW{1'b1}} : link_sum[LinkW-1:0];
          else if (state_i.link_count != '0)
            st.link_count = state_i.link_count - 1'b1;
        end
        default: st.link_count = '0;
      endcase
    end

    // tenths of a second spent pairing
    if (tenth_due && st.pairing_count != {PairW{1'b1}})
      st.pairing_count = st.pairing_count + 1'b1;

    // key debounce and press edge
    if (key_level_i != st.debounced_key) begin
      if (st.debounce_count > cfg_i.debounce_ms) begin
        st.debounced_key  = key_level_i;
        st.debounce_count = '0;
      end
    end else begin
      pressed           = ~st.debounced_key;
      st.debounce_count = '0;
      st.key_edge       = pressed & ~st.key_held;
      st.key_held       = pressed;
    end
    if (st.key_held && st.key_edge) st.press_armed = 1'b1;

    // short press on release cycles the lamp
    if (!st.key_held) begin
      if (st.press_armed) begin
        case (st.lamp_state)
          LampHalf: st.lamp_state = LampFull;
          LampFull: st.lamp_state = LampOff;
          default:  st.lamp_state = LampHalf;
        endcase
      end
      st.press_armed = 1'b0;
      st.press_count = '0;
    end

    // long press toggles the radio
    if (st.press_armed && st.press_count > cfg_i.long_press_ms) begin
      st.press_armed = 1'b0;
      st.radio_state = (st.radio_state == RadioOff) ? RadioPair : RadioOff;
    end

    // pairing <-> connected by link count
    if (st.radio_state != RadioOff && st.link_count > cfg_i.status_confirm_ms) begin
      st.link_count  = '0;
      st.radio_state = (st.radio_state == RadioPair) ? RadioConn : RadioPair;
    end

    // link LED and pairing timeout
    case (st.radio_state)
      RadioPair: begin
        if (st.blink_due) begin
          st.blink_due = 1'b0;
          st.led_level = ~st.led_level;
        end
        if (st.pairing_count > cfg_i.pairing_timeout) begin
          st.pairing_count = '0;
          st.radio_state   = RadioOff;
          st.led_level     = 1'b0;
        end
      end
      RadioConn: begin
        st.pairing_count = '0;
        st.led_level     = 1'b1;
      end
      default: begin
        st.pairing_count = '0;
        st.led_level     = 1'b0;
      end
    endcase

    // any activity restarts the idle timer
    if (st.lamp_state != LampOff || st.radio_state != RadioOff) st.idle_count = '0;
  end

  // outputs
  assign state_o       = st;
  assign tenth_count_o = tenth_cnt;

  assign result_o.lamp_mode        = st.lamp_state;
  assign result_o.lamp_low_enable  = (st.lamp_state == LampHalf) || (st.lamp_state == LampFull);
  assign result_o.lamp_high_enable = (st.lamp_state == LampFull);
  assign result_o.radio_mode       = st.radio_state;
  assign result_o.radio_enable     = (st.radio_state == RadioPair) ||
                                     (st.radio_state == RadioConn);
  assign result_o.radio_led        = st.led_level;
  assign result_o.sleep_request    = sleep_due;

endmodule

// ----- src/lamp_and_radio_button_controller_core.sv -----
`timescale 1ns / 1ps
// top level of the lamp and radio button controller
//
// Each transfer on the input channel is one poll of the control loop (tick flag, raw
// active-low key, link status) and yields exactly one result transfer with the lamp and
// radio modes, driver enables, link LED and a one-shot sleep request. A poll is taken
// into an input register, the single-pass update logic between that register and the
// result register advances all timers and state, and the result is written into the result
// register. One poll is taken every clock cycle as long as the result side keeps up;
// the result register decouples the two sides so a new poll is taken while a finished
// result still waits. Configuration writes take effect at once
// and are meant to be issued while no poll is in flight.
module lamp_and_radio_button_controller_core #(
  parameter int unsigned TICKS_PER_TENTH = lrbc_pkg::TicksPerTenthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [lrbc_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [lrbc_pkg::CfgDataW-1:0]    cfg_data_i,
  // poll channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             tick_elapsed_i,
  input  logic                             key_level_i,
  input  logic                             link_status_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lrbc_pkg::ModeW-1:0]       lamp_mode_o,
  output logic                             lamp_low_enable_o,
  output logic                             lamp_high_enable_o,
  output logic [lrbc_pkg::ModeW-1:0]       radio_mode_o,
  output logic                             radio_enable_o,
  output logic                             radio_led_o,
  output logic                             sleep_request_o
);
  import lrbc_pkg::*;

  localparam int unsigned TenthW = (TICKS_PER_TENTH > 1) ? $clog2(TICKS_PER_TENTH) : 1;

  // controller state after reset: lamp and radio off, everything else cleared
  localparam state_t StateRst = '{lamp_state: LampOff, radio_state: RadioOff, default: '0};

  cfg_t              cfg;
  state_t            state_q, state_d;
  logic [TenthW-1:0] tenth_count_q, tenth_count_d;
  logic              in_valid_q;
  logic              tick_q, key_q, link_q;
  logic              out_valid_q;
  result_t           result_q, result_d;
  logic              advance;

  lrbc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lrbc_step #(
    .TICKS_PER_TENTH (TICKS_PER_TENTH),
    .TenthW          (TenthW)
  ) u_step (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .tenth_count_i  (tenth_count_q),
    .tick_elapsed_i (tick_q),
    .key_level_i    (key_q),
    .link_status_i  (link_q),
    .state_o        (state_d),
    .tenth_count_o  (tenth_count_d),
    .result_o       (result_d)
  );

  // a poll moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tick_q <= tick_elapsed_i;
      key_q  <= key_level_i;
      link_q <= link_status_i;
    end
  end

  // controller state, updated once per poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= StateRst;
      tenth_count_q         <= '0;
    end else if (advance) begin
      state_q       <= state_d;
      tenth_count_q <= tenth_count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  // result ports
  assign out_valid_o        = out_valid_q;
  assign lamp_mode_o        = result_q.lamp_mode;
  assign lamp_low_enable_o  = result_q.lamp_low_enable;
  assign lamp_high_enable_o = result_q.lamp_high_enable;
  assign radio_mode_o       = result_q.radio_mode;
  assign radio_enable_o     = result_q.radio_enable;
  assign radio_led_o        = result_q.radio_led;
  assign sleep_request_o    = result_q.sleep_request;

endmodule
